### hdl/md5_pkg.sv
package md5_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] i;
        case (r[5:4])
            2'd0:    i = r[3:0];
            2'd1:    i = 4'(5 * r + 1);
            2'd2:    i = 4'(3 * r + 5);
            default: i = 4'(7 * r);
        endcase
        return i;
    endfunction

endpackage

### hdl/md5_message_digest_unit.sv
// MD5 digest unit, one message byte per input transfer.
// Input channel (i_in_valid/o_in_ready, t_in_item): func 0 appends data_byte,
// func 1 finishes the message. Output channel (o_out_valid/i_out_ready,
// t_out_item) carries four digest words per finish, index 0 first.
// Bytes are packed little-endian into a 16-word block memory with a
// registered read; each append is written as it is accepted. The 64th
// byte of a block starts a compression of 64 rounds, one round per cycle,
// after a prime state that starts the memory read and before a fold into
// the chain value; input is held off throughout. A finish writes the pad
// marker and zero fill one word per cycle, then the length words, runs one
// or two compressions (two when the marker leaves no room for the length),
// then emits the four words, one per cycle while the receiver takes them;
// a stalled receiver holds the current word. The round loop through the
// shared adder chain dominates the time per block.
// Synchronous active-low reset loads the MD5 initial vector and clears the
// byte and fill counts; the block memory needs no clearing.
module md5_message_digest_unit
    import md5_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_PRIME, S_ROUND, S_FOLD, S_EMIT
    } t_state;

    t_state      r_state;
    logic [31:0] r_mem [16];
    logic [31:0] r_rd;
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_fill;
    logic [63:0] r_count;
    logic [5:0]  r_round;
    logic [4:0]  r_pad;      // word pointer for fill, bit 4 = done
    logic        r_finish;   // compression belongs to a finish
    logic        r_second;   // fill is for the length-only second block of a finish
    logic [1:0]  r_oidx;
    logic [31:0] r_part;     // word under assembly

    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
    logic [31:0] f_val, sum, rot;
    logic [4:0]  sh;
    logic [5:0]  fill_nx;
    logic [63:0] bits;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_data.digest_word = r_h[r_oidx];
    assign o_out_data.word_index  = r_oidx;
    assign o_out_data.last_word   = (r_oidx == 2'd3);
    assign bits    = {r_count[60:0], 3'b000};
    assign fill_nx = r_fill + 6'd1;

    // Block memory write: merge byte into the word under assembly, or write pad marker, zero fill and length words
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_fill[5:2];
        wr_data = r_part;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_data.func == FUNC_APPEND) begin
                    wr_en = 1'b1;
                    case (r_fill[1:0])
                        2'd0:    wr_data = {24'h0, i_in_data.data_byte};
                        2'd1:    wr_data = {16'h0, i_in_data.data_byte, r_part[7:0]};
                        2'd2:    wr_data = {8'h0, i_in_data.data_byte, r_part[15:0]};
                        default: wr_data = {i_in_data.data_byte, r_part[23:0]};
                    endcase
                end
            end
            S_PAD: begin
                wr_en   = 1'b1;
                wr_addr = r_pad[3:0];
                if (r_pad[3:0] == r_fill[5:2] && !r_second) begin
                    case (r_fill[1:0])
                        2'd0:    wr_data = {24'h0, PAD_MARK};
                        2'd1:    wr_data = {16'h0, PAD_MARK, r_part[7:0]};
                        2'd2:    wr_data = {8'h0, PAD_MARK, r_part[15:0]};
                        default: wr_data = {PAD_MARK, r_part[23:0]};
                    endcase
                end else begin
                    wr_data = 32'h0;
                end
            end
            S_LEN: begin
                wr_en   = 1'b1;
                wr_addr = r_pad[0] ? 4'd15 : 4'd14;
                wr_data = r_pad[0] ? bits[63:32] : bits[31:0];
            end
            default: ;
        endcase
    end

    // Round logic
    always_comb begin
        case (r_round[5:4])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f_val + round_k(r_round) + r_rd;
        sh  = rot_amount(r_round);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
        rd_addr = (r_state == S_ROUND) ? msg_index(r_round + 6'd1) : msg_index(6'd0);
    end

    // Block memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_h[0]   <= IV0;
            r_h[1]   <= IV1;
            r_h[2]   <= IV2;
            r_h[3]   <= IV3;
            r_fill   <= '0;
            r_count  <= '0;
            r_round  <= '0;
            r_pad    <= '0;
            r_finish <= 1'b0;
            r_second <= 1'b0;
            r_oidx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.func == FUNC_APPEND) begin
                            r_part  <= (r_fill[1:0] == 2'd3) ? 32'h0 : wr_data;
                            r_fill  <= fill_nx;
                            r_count <= r_count + 64'd1;
                            if (fill_nx == 6'd0) begin
                                r_finish <= 1'b0;
                                r_state  <= S_PRIME;
                            end
                        end else begin
                            r_finish <= 1'b1;
                            r_second <= 1'b0;
                            r_pad    <= {1'b0, r_fill[5:2]};
                            r_state  <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (r_pad[3:0] == 4'd15 && (r_second || r_fill < LEN_POS)) begin
                        r_pad   <= '0;
                        r_state <= S_LEN;
                    end else begin
                        r_pad <= r_pad + 5'd1;
                        if (r_pad[3:0] == 4'd15) begin
                            r_state <= S_PRIME;
                        end
                    end
                end
                S_LEN: begin
                    r_pad <= r_pad + 5'd1;
                    if (r_pad[0]) begin
                        r_second <= 1'b0;
                        r_state  <= S_PRIME;
                    end
                end
                S_PRIME: begin
                    r_a     <= r_h[0];
                    r_b     <= r_h[1];
                    r_c     <= r_h[2];
                    r_d     <= r_h[3];
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_a     <= r_d;
                    r_d     <= r_c;
                    r_c     <= r_b;
                    r_b     <= r_b + rot;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    if (!r_finish) begin
                        r_state <= S_IDLE;
                    end else if (r_fill >= LEN_POS && !r_second && r_pad[4]) begin
                        // first of two finish blocks done: zero fill then length
                        r_second <= 1'b1;
                        r_pad    <= '0;
                        r_state  <= S_PAD;
                    end else begin
                        r_oidx  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_h[0]   <= IV0;
                            r_h[1]   <= IV1;
                            r_h[2]   <= IV2;
                            r_h[3]   <= IV3;
                            r_fill   <= '0;
                            r_count  <= '0;
                            r_finish <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/sv/md5_digest_checker.sv
module md5_digest_checker
    import md5_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                   4, 11, 16, 23, 6, 10, 15, 21};

    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [5:0]  fill;
    logic [63:0] nbytes;
    t_out_item   digest_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = digest_q.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Run the 64 rounds over the current block and fold into the chain
    task automatic compress();
        logic [31:0] a, b, c, d, f, t;
        int g, idx;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int r = 0; r < 64; r++) begin
            g = r / 16;
            case (g)
                0: begin f = (b & c) | (~b & d); idx = r; end
                1: begin f = (b & d) | (c & ~d); idx = 5 * r + 1; end
                2: begin f = b ^ c ^ d; idx = 3 * r + 5; end
                default: begin f = c ^ (b | ~d); idx = 7 * r; end
            endcase
            t = a + f + SINE_K[r] + blk[idx % 16];
            a = d; d = c; c = b;
            b = b + rotl(t, SHIFTS[g * 4 + r % 4]);
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic put_byte(input int pos, input logic [7:0] v);
        if (pos % 4 == 0) blk[pos / 4] = {24'h0, v};
        else blk[pos / 4][(pos % 4) * 8 +: 8] = v;
    endtask

    task automatic restart_digest();
        chain = '{IV0, IV1, IV2, IV3};
        fill = '0;
        nbytes = '0;
    endtask

    // Advance the digest model by one accepted input transfer
    task automatic absorb_item(input t_in_item it);
        logic [63:0] bits;
        t_out_item o;
        if (it.func == FUNC_APPEND) begin
            put_byte(fill, it.data_byte);
            nbytes++;
            fill++;
            if (fill == 0) compress();
        end else begin
            bits = nbytes << 3;
            put_byte(fill, PAD_MARK);
            for (int i = fill + 1; i < 64; i++) put_byte(i, 8'h00);
            if (fill >= LEN_POS) begin
                compress();
                for (int i = 0; i < 16; i++) blk[i] = '0;
            end
            blk[14] = bits[31:0];
            blk[15] = bits[63:32];
            compress();
            for (int i = 0; i < 4; i++) begin
                o.digest_word = chain[i];
                o.word_index  = 2'(i);
                o.last_word   = (i == 3);
                digest_q.push_back(o);
            end
            restart_digest();
        end
    endtask

    initial begin
        fails = 0;
        restart_digest();
    end

    // Predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) absorb_item(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("digest word with none expected");
                end else begin
                    want = digest_q.pop_front();
                    if (i_out_data.digest_word !== want.digest_word)
                        report_mismatch($sformatf("digest_word %h, want %h",
                            i_out_data.digest_word, want.digest_word));
                    if (i_out_data.word_index !== want.word_index)
                        report_mismatch($sformatf("word_index %0d, want %0d",
                            i_out_data.word_index, want.word_index));
                    if (i_out_data.last_word !== want.last_word)
                        report_mismatch($sformatf("last_word %b, want %b",
                            i_out_data.last_word, want.last_word));
                end
            end
        end
    end

endmodule

### tb/sv/md5_message_digest_unit_tb.sv
module md5_message_digest_unit_tb;
    import md5_pkg::*;

    localparam int BOUND_LENS [4] = '{55, 56, 63, 64};

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;
    int        fail_count;
    int        pending;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    always #2 i_clk = ~i_clk;

    md5_message_digest_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    md5_digest_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_out_data(o_out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall at random per current phase
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold one transfer on the input channel until accepted; valid stays
    // high afterward until the next call drops it or sends again
    task automatic send_item(input logic fn, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_data  <= '{func: fn, data_byte: b};
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_item(FUNC_APPEND, 8'($urandom));
        send_item(FUNC_FINISH, 8'($urandom));
    endtask

    initial begin
        int sent;
        int len;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: empty message, "abc", byte extremes, finish ignoring its byte
        send_item(FUNC_FINISH, 8'h00);
        send_item(FUNC_APPEND, 8'h61);
        send_item(FUNC_APPEND, 8'h62);
        send_item(FUNC_APPEND, 8'h63);
        send_item(FUNC_FINISH, 8'hff);
        send_item(FUNC_APPEND, 8'h00);
        send_item(FUNC_APPEND, 8'hff);
        send_item(FUNC_APPEND, 8'h55);
        send_item(FUNC_APPEND, 8'haa);
        send_item(FUNC_FINISH, 8'h5a);
        // Lengths at the padding boundaries
        sent = 10;
        for (int k = 0; k < 4; k++) begin
            send_message(BOUND_LENS[k]);
            sent += BOUND_LENS[k] + 1;
        end
        // Random messages across the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            while (sent < 252 + 40 * (ph + 1)) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(70) : $urandom_range(12);
                send_message(len);
                sent += len + 1;
            end
        end
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
